### sv/bcs_pkg.sv
`timescale 1ns / 1ps

package bcs_pkg;

	localparam int SetBits = 10;
	localparam logic [SetBits-1:0] SettingMax = 10'd1000;

	// scale factors applied before the divide by 1000
	localparam logic [7:0] MultB = 8'd255;
	localparam logic [7:0] MultC = 8'd127;
	localparam logic [7:0] MultS = 8'd31;
	localparam logic [9:0] RoundHalf = 10'd500;

	// floor(n / 1000) = (n * DivRecip) >> DivShift, exact for n < 2^18
	localparam int DivShift = 28;
	localparam logic [18:0] DivRecip = 19'd268436;

	localparam logic [7:0] CtrMid = 8'd64;

	// reciprocal of D = 192 - C for high contrast, ceil(2^21 / D), indexed by C - 64
	localparam int RcpBits = 15;
	localparam int RcpNum = 2 ** 21;
	localparam logic [RcpBits-1:0] RcpTable [0:63] = '{
		15'((RcpNum + 127) / 128), 15'((RcpNum + 126) / 127),
		15'((RcpNum + 125) / 126), 15'((RcpNum + 124) / 125),
		15'((RcpNum + 123) / 124), 15'((RcpNum + 122) / 123),
		15'((RcpNum + 121) / 122), 15'((RcpNum + 120) / 121),
		15'((RcpNum + 119) / 120), 15'((RcpNum + 118) / 119),
		15'((RcpNum + 117) / 118), 15'((RcpNum + 116) / 117),
		15'((RcpNum + 115) / 116), 15'((RcpNum + 114) / 115),
		15'((RcpNum + 113) / 114), 15'((RcpNum + 112) / 113),
		15'((RcpNum + 111) / 112), 15'((RcpNum + 110) / 111),
		15'((RcpNum + 109) / 110), 15'((RcpNum + 108) / 109),
		15'((RcpNum + 107) / 108), 15'((RcpNum + 106) / 107),
		15'((RcpNum + 105) / 106), 15'((RcpNum + 104) / 105),
		15'((RcpNum + 103) / 104), 15'((RcpNum + 102) / 103),
		15'((RcpNum + 101) / 102), 15'((RcpNum + 100) / 101),
		15'((RcpNum + 99) / 100), 15'((RcpNum + 98) / 99),
		15'((RcpNum + 97) / 98), 15'((RcpNum + 96) / 97),
		15'((RcpNum + 95) / 96), 15'((RcpNum + 94) / 95),
		15'((RcpNum + 93) / 94), 15'((RcpNum + 92) / 93),
		15'((RcpNum + 91) / 92), 15'((RcpNum + 90) / 91),
		15'((RcpNum + 89) / 90), 15'((RcpNum + 88) / 89),
		15'((RcpNum + 87) / 88), 15'((RcpNum + 86) / 87),
		15'((RcpNum + 85) / 86), 15'((RcpNum + 84) / 85),
		15'((RcpNum + 83) / 84), 15'((RcpNum + 82) / 83),
		15'((RcpNum + 81) / 82), 15'((RcpNum + 80) / 81),
		15'((RcpNum + 79) / 80), 15'((RcpNum + 78) / 79),
		15'((RcpNum + 77) / 78), 15'((RcpNum + 76) / 77),
		15'((RcpNum + 75) / 76), 15'((RcpNum + 74) / 75),
		15'((RcpNum + 73) / 74), 15'((RcpNum + 72) / 73),
		15'((RcpNum + 71) / 72), 15'((RcpNum + 70) / 71),
		15'((RcpNum + 69) / 70), 15'((RcpNum + 68) / 69),
		15'((RcpNum + 67) / 68), 15'((RcpNum + 66) / 67),
		15'((RcpNum + 65) / 66), 15'((RcpNum + 64) / 65)
	};

	typedef struct packed {
		logic [SetBits-1:0] brightness;
		logic [SetBits-1:0] contrast;
		logic [SetBits-1:0] saturation;
	} settings_t;

	typedef struct packed {
		logic [7:0] b;
		logic [6:0] c;
		logic [4:0] s;
	} scaled_t;

	typedef struct packed {
		logic       hi;
		logic [7:0] b;
		logic [6:0] c;
		logic [7:0] gain;
		logic [6:0] quot;
		logic [7:0] chroma;
	} coef_t;

endpackage

### sv/bcs_scale.sv
`timescale 1ns / 1ps

module bcs_scale import bcs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      set_valid,
	output logic      set_ready,
	input  settings_t set_data,
	output logic      scl_valid,
	input  logic      scl_ready,
	output scaled_t   scl_data
);

	logic            vld_s1, vld_s2;
	logic            rdy_s1, rdy_s2;
	logic [17:0]     pb_s1, pc_s1, ps_s1;
	scaled_t         scl_s2;
	logic [SetBits-1:0] xb, xc, xs;
	logic [17:0]     pb, pc, ps;
	logic [17:0]     nb, nc, ns;
	logic [36:0]     qb, qc, qs;

	function automatic logic [SetBits-1:0] sat_set(input logic [SetBits-1:0] v);
		return (v > SettingMax) ? SettingMax : v;
	endfunction

	assign rdy_s2    = !vld_s2 || scl_ready;
	assign rdy_s1    = !vld_s1 || rdy_s2;
	assign set_ready = rdy_s1;
	assign scl_valid = vld_s2;
	assign scl_data  = scl_s2;

	always_comb begin
		xb = sat_set(set_data.brightness);
		xc = sat_set(set_data.contrast);
		xs = sat_set(set_data.saturation);
		pb = 18'(xb) * 18'(MultB);
		pc = 18'(xc) * 18'(MultC);
		ps = 18'(xs) * 18'(MultS);
	end

	// round half up, then divide by 1000 through the reciprocal
	always_comb begin
		nb = pb_s1 + 18'(RoundHalf);
		nc = pc_s1 + 18'(RoundHalf);
		ns = ps_s1 + 18'(RoundHalf);
		qb = 37'(nb) * 37'(DivRecip);
		qc = 37'(nc) * 37'(DivRecip);
		qs = 37'(ns) * 37'(DivRecip);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= set_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && set_valid) begin
			pb_s1 <= pb;
			pc_s1 <= pc;
			ps_s1 <= ps;
		end
		if (rdy_s2 && vld_s1) begin
			scl_s2.b <= qb[DivShift +: 8];
			scl_s2.c <= qc[DivShift +: 7];
			scl_s2.s <= qs[DivShift +: 5];
		end
	end

endmodule

### sv/bcs_coef.sv
`timescale 1ns / 1ps

module bcs_coef import bcs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    scl_valid,
	output logic    scl_ready,
	input  scaled_t scl_data,
	output logic    coef_valid,
	input  logic    coef_ready,
	output coef_t   coef_data
);

	logic               vld_s3, vld_s4;
	logic               rdy_s3, rdy_s4;
	logic               hi_s3;
	logic [7:0]         b_s3;
	logic [6:0]         c_s3;
	logic [4:0]         s_s3;
	logic [RcpBits-1:0] rcp_s3;
	logic [11:0]        plo_s3;
	coef_t              coef_s4;
	logic [7:0]         ce, ce3;
	logic [11:0]        plo;
	logic [20:0]        qm;
	logic [19:0]        km;
	coef_t              coef;

	assign rdy_s4     = !vld_s4 || coef_ready;
	assign rdy_s3     = !vld_s3 || rdy_s4;
	assign scl_ready  = rdy_s3;
	assign coef_valid = vld_s4;
	assign coef_data  = coef_s4;

	always_comb begin
		ce  = 8'(scl_data.c) + CtrMid;
		plo = 12'(scl_data.s) * 12'(ce);
	end

	// high contrast: quotients by D through the reciprocal of D; low contrast: gain and chroma from C + 64, quotient zero
	always_comb begin
		ce3         = 8'(c_s3) + CtrMid;
		qm          = 21'(c_s3[5:0]) * 21'(rcp_s3);
		km          = 20'(s_s3) * 20'(rcp_s3);
		coef.hi     = hi_s3;
		coef.b      = b_s3;
		coef.c      = c_s3;
		if (hi_s3) begin
			coef.gain   = {1'b0, rcp_s3[RcpBits-1:8]};
			coef.quot   = qm[20:14];
			coef.chroma = km[19:12];
		end else begin
			coef.gain   = {1'b0, ce3[7:1]};
			coef.quot   = '0;
			coef.chroma = {1'b0, plo_s3[11:5]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy_s3) vld_s3 <= scl_valid;
			if (rdy_s4) vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && scl_valid) begin
			hi_s3  <= scl_data.c[6];
			b_s3   <= scl_data.b;
			c_s3   <= scl_data.c;
			s_s3   <= scl_data.s;
			rcp_s3 <= RcpTable[scl_data.c[5:0]];
			plo_s3 <= plo;
		end
		if (rdy_s4 && vld_s3) coef_s4 <= coef;
	end

endmodule

### sv/bcs_coefficient_compute.sv
`timescale 1ns / 1ps
// An input transfer passes through stages s1 to s5 before its result is on m_axis.
// Throughput: one settings triple per cycle; the five register stages each
// hold their item only while the stage behind them is stalled.
// Reset (arst_n low) clears the stage valid bits; data registers are not reset.

module bcs_coefficient_compute import bcs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // brightness[9:0], contrast[19:10], saturation[29:20]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata   // luma_word[15:0], chroma_word[31:16]
);

	settings_t        set_data;
	logic             scl_valid, scl_ready;
	scaled_t          scl_data;
	logic             coef_valid, coef_ready;
	coef_t            coef_data;
	logic             vld_s5;
	logic [31:0]      tdata_s5;
	logic signed [9:0] off_hi, off_lo, off;

	assign set_data.brightness = s_axis_tdata[9:0];
	assign set_data.contrast   = s_axis_tdata[19:10];
	assign set_data.saturation = s_axis_tdata[29:20];

	bcs_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.set_valid (s_axis_tvalid),
		.set_ready (s_axis_tready),
		.set_data  (set_data),
		.scl_valid (scl_valid),
		.scl_ready (scl_ready),
		.scl_data  (scl_data)
	);

	bcs_coef u_coef (
		.clk        (clk),
		.arst_n     (arst_n),
		.scl_valid  (scl_valid),
		.scl_ready  (scl_ready),
		.scl_data   (scl_data),
		.coef_valid (coef_valid),
		.coef_ready (coef_ready),
		.coef_data  (coef_data)
	);

	assign coef_ready    = !vld_s5 || m_axis_tready;
	assign m_axis_tvalid = vld_s5;
	assign m_axis_tdata  = tdata_s5;

	// offset clamps: floor at -128 for high contrast, ceiling at 127 for low
	always_comb begin
		off_hi = $signed({2'b00, coef_data.b}) - 10'sd128 - $signed({3'b000, coef_data.quot});
		off_lo = $signed({2'b00, coef_data.b}) - $signed({3'b000, coef_data.c}) - 10'sd64;
		if (coef_data.hi) begin
			off = (off_hi < -10'sd128) ? -10'sd128 : off_hi;
		end else begin
			off = (off_lo > 10'sd127) ? 10'sd127 : off_lo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (coef_ready) begin
			vld_s5 <= coef_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (coef_ready && coef_valid) begin
			tdata_s5 <= {coef_data.chroma, coef_data.chroma, coef_data.gain, off[7:0]};
		end
	end

	a_gain_hi: assert property (@(posedge clk) disable iff (!arst_n)
		coef_valid && coef_data.hi |-> coef_data.gain >= 8'd64 && coef_data.gain <= 8'd126)
		else $error("high contrast gain out of range");

	a_chroma_hi: assert property (@(posedge clk) disable iff (!arst_n)
		coef_valid && coef_data.hi |-> coef_data.chroma <= 8'd244)
		else $error("high contrast chroma gain out of range");

	a_chroma_lo: assert property (@(posedge clk) disable iff (!arst_n)
		coef_valid && !coef_data.hi |-> coef_data.chroma <= 8'd123 && coef_data.quot == 7'd0)
		else $error("low contrast chroma gain out of range");

	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output stage");

endmodule
